// File: rtl/priority_graph_reachability_defines.svh
// assertion macros for the priority graph reachability block
// expects clk and rst_n in the scope of each use; define NO_ASSERTIONS to drop them
`ifndef PRIORITY_GRAPH_REACHABILITY_DEFINES_SVH
`define PRIORITY_GRAPH_REACHABILITY_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PGR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PGR_ASSERT_SAME(lbl, ante, cons, msg)

`define PGR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/pgr_pkg.sv
// shared types and constants for the priority graph reachability block
// no dependencies
`default_nettype none

package pgr_pkg;

    localparam int REQ_W  = 2;
    localparam int NODE_W = 6;
    localparam int MASK_W = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } req_t;

endpackage

`default_nettype wire

// File: rtl/pgr_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module pgr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/priority_graph_reachability.sv
// clear and out of range requests go straight to the result; an edge add or remove reads the
// row then writes it; a query reads the root row, merges it, then reads and merges one row per
// reached node; no new item is taken until the result of the previous one is registered;
// a new item is taken while the previous result still waits, but its result stalls behind it
// reset clears the per-row valid bits so every row reads as empty; no clearing pass
// depends on pgr_pkg, pgr_ram and priority_graph_reachability_defines.svh
`default_nettype none

`include "priority_graph_reachability_defines.svh"

module priority_graph_reachability
    import pgr_pkg::*;
#(
    parameter int NODES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [NODE_W-1:0] from_node,
    input  wire logic [NODE_W-1:0] to_node,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output logic [MASK_W-1:0]      reach_mask,
    output logic                   is_connected
);

    localparam int AW = $clog2(NODES);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EDIT_RD  = 8'b0000_0010,
        S_EDIT_WR  = 8'b0000_0100,
        S_ROOT_RD  = 8'b0000_1000,
        S_ROOT_MRG = 8'b0001_0000,
        S_ISSUE    = 8'b0010_0000,
        S_MERGE    = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    req_t              op_reg;
    logic [AW-1:0]     from_reg, to_reg;
    logic              range_reg;
    logic [NODES-1:0]  row_valid_reg;
    logic              rd_valid_reg;
    logic [NODES-1:0]  reach_reg, reach_next;
    logic [NODES-1:0]  expl_reg, expl_next;
    logic              rsp_valid_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              conn_reg;

    logic              req_fire;
    logic              in_range;
    logic              rsp_free;
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [NODES-1:0]  ram_wdata;
    logic [NODES-1:0]  ram_rdata;
    logic [NODES-1:0]  row_eff;
    logic [NODES-1:0]  to_bit;
    logic [NODES-1:0]  cand;
    logic              pick_any;
    logic [AW-1:0]     pick_idx;
    logic              res_query;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign in_range  = (32'(from_node) < NODES) && (32'(to_node) < NODES);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign row_eff = ram_rdata & {NODES{rd_valid_reg}};
    assign to_bit  = NODES'(1) << to_reg;
    assign cand    = reach_reg & ~expl_reg;
    assign pick_any = |cand;

    // lowest pending node
    always_comb
    begin
        pick_idx = '0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick_idx = AW'(i);
            end
        end
    end

    assign ram_raddr = (state_reg == S_ISSUE) ? pick_idx : from_reg;
    assign ram_wdata = (op_reg == REQ_ADD) ? (row_eff | to_bit) : (row_eff & ~to_bit);

    pgr_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (from_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        reach_next = reach_reg;
        expl_next  = expl_reg;
        ram_we     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type inside {REQ_ADD, REQ_REMOVE})
                    begin
                        state_next = in_range ? S_EDIT_RD : S_RESULT;
                    end
                    else if (req_type == REQ_QUERY)
                    begin
                        state_next = in_range ? S_ROOT_RD : S_RESULT;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_EDIT_RD:
            begin
                state_next = S_EDIT_WR;
            end
            S_EDIT_WR:
            begin
                ram_we     = 1'b1;
                state_next = S_RESULT;
            end
            S_ROOT_RD:
            begin
                state_next = S_ROOT_MRG;
            end
            S_ROOT_MRG:
            begin
                reach_next = row_eff;
                expl_next  = '0;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (pick_any)
                begin
                    expl_next[pick_idx] = 1'b1;
                    state_next          = S_MERGE;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_MERGE:
            begin
                reach_next = reach_reg | row_eff;
                state_next = S_ISSUE;
            end
            S_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            reach_reg     <= '0;
            expl_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            reach_reg    <= reach_next;
            expl_reg     <= expl_next;
            rd_valid_reg <= row_valid_reg[ram_raddr];
            if (req_fire && (req_type == REQ_CLEAR))
            begin
                row_valid_reg <= '0;
            end
            else if (ram_we)
            begin
                row_valid_reg[from_reg] <= 1'b1;
            end
            if ((state_reg == S_RESULT) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg    <= req_t'(req_type);
            from_reg  <= from_node[AW-1:0];
            to_reg    <= to_node[AW-1:0];
            range_reg <= in_range;
        end
    end

    assign res_query = (op_reg == REQ_QUERY) && range_reg;

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RESULT) && rsp_free)
        begin
            mask_reg <= res_query ? MASK_W'(reach_reg) : '0;
            conn_reg <= res_query && reach_reg[to_reg];
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign reach_mask   = mask_reg;
    assign is_connected = conn_reg;

    `PGR_ASSERT_SAME(a_expl_subset, 1'b1, (expl_reg & ~reach_reg) == '0, "explored not reached")
    `PGR_ASSERT_NEXT(a_issue_done, (state_reg == S_ISSUE) && !pick_any, state_reg == S_RESULT, "no end")
    `PGR_ASSERT_NEXT(a_clear_rows, req_fire && (req_type == REQ_CLEAR), row_valid_reg == '0, "clear")
    `PGR_ASSERT_SAME(a_conn_mask, rsp_valid_reg && conn_reg, mask_reg != '0, "connected, empty mask")

endmodule

`default_nettype wire
